>>> hdl/gado_pkg.sv
// Shared widths, constants, codes and helper functions for the drive odometry block.
package gado_pkg;

  localparam int DELTA_W    = 16;
  localparam int ANG_W      = 16;
  localparam int GAIN_W     = 16;
  localparam int POS_W      = 32;
  localparam int SUM_W      = 19;                 // six 16-bit deltas
  localparam int TRAVEL_W   = 35;                 // sum * gain, Q16 fraction
  localparam int CW         = 33;                 // CORDIC x/y
  localparam int ZW         = 32;                 // CORDIC angle, 2^32 per turn
  localparam int C16_W      = 18;                 // rounded sin/cos, Q16
  localparam int PROD_W     = TRAVEL_W + C16_W;
  localparam int STEP_W     = 22;                 // per-tick dx/dy
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int ATAN_IDX_W = 5;

  localparam logic [GAIN_W-1:0]       TRAVEL_GAIN_RST = 16'd3304;
  localparam logic signed [POS_W-1:0] START_X_RST     = 32'sd9216;
  localparam logic signed [POS_W-1:0] START_Y_RST     = 32'sd3072;
  localparam logic signed [CW-1:0]    CORDIC_K        = 33'sh0_26DD_3B6A;
  localparam logic signed [PROD_W:0]  RND_HALF        = (PROD_W+1)'(64'sh8000_0000);
  localparam logic signed [CW:0]      C_RND_HALF      = (CW+1)'(64'sd8192);
  localparam logic [ANG_W-1:0]        OCTANT_BIAS     = 16'd8192;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRAVEL_GAIN = 2'd0,
    CFG_START_X     = 2'd1,
    CFG_START_Y     = 2'd2
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_MULX,
    ST_MULY,
    ST_UPD
  } state_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic signed [ZW-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [ZW-1:0] a;
    unique case (idx)
      5'd0:  a = 32'sh2000_0000;
      5'd1:  a = 32'sh12E4_051E;
      5'd2:  a = 32'sh09FB_385B;
      5'd3:  a = 32'sh0511_11D4;
      5'd4:  a = 32'sh028B_0D43;
      5'd5:  a = 32'sh0145_D7E1;
      5'd6:  a = 32'sh00A2_F61E;
      5'd7:  a = 32'sh0051_7C55;
      5'd8:  a = 32'sh0028_BE53;
      5'd9:  a = 32'sh0014_5F2F;
      5'd10: a = 32'sh000A_2F98;
      5'd11: a = 32'sh0005_17CC;
      5'd12: a = 32'sh0002_8BE6;
      5'd13: a = 32'sh0001_45F3;
      5'd14: a = 32'sh0000_A2FA;
      5'd15: a = 32'sh0000_517D;
      5'd16: a = 32'sh0000_28BE;
      5'd17: a = 32'sh0000_145F;
      5'd18: a = 32'sh0000_0A30;
      5'd19: a = 32'sh0000_0518;
      5'd20: a = 32'sh0000_028C;
      5'd21: a = 32'sh0000_0146;
      5'd22: a = 32'sh0000_00A3;
      5'd23: a = 32'sh0000_0051;
      default: a = '0;
    endcase
    return a;
  endfunction

  function automatic logic signed [POS_W-1:0] sat32(input logic signed [POS_W:0] v);
    logic signed [POS_W-1:0] r;
    if (v[POS_W] != v[POS_W-1]) begin
      r = v[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> hdl/gado_if.sv
// Valid/ready channel interfaces for odometry samples and position results.
interface gado_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [gado_pkg::DELTA_W-1:0] left_front_delta;
  logic signed [gado_pkg::DELTA_W-1:0] left_middle_delta;
  logic signed [gado_pkg::DELTA_W-1:0] left_back_delta;
  logic signed [gado_pkg::DELTA_W-1:0] right_front_delta;
  logic signed [gado_pkg::DELTA_W-1:0] right_middle_delta;
  logic signed [gado_pkg::DELTA_W-1:0] right_back_delta;
  logic        [gado_pkg::ANG_W-1:0]   heading_angle;

  modport source (
    output valid, left_front_delta, left_middle_delta, left_back_delta,
           right_front_delta, right_middle_delta, right_back_delta, heading_angle,
    input  ready
  );
  modport sink (
    input  valid, left_front_delta, left_middle_delta, left_back_delta,
           right_front_delta, right_middle_delta, right_back_delta, heading_angle,
    output ready
  );
endinterface

interface gado_result_if;
  logic                              valid;
  logic                              ready;
  logic signed [gado_pkg::POS_W-1:0] pos_x;
  logic signed [gado_pkg::POS_W-1:0] pos_y;
  logic        [gado_pkg::ANG_W-1:0] heading_out;

  modport source (output valid, pos_x, pos_y, heading_out, input ready);
  modport sink (input valid, pos_x, pos_y, heading_out, output ready);
endinterface

>>> hdl/gado_cordic.sv
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, then quadrant fix and Q16 round.
module gado_cordic #(
  parameter int STEPS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic        [gado_pkg::ANG_W-1:0]   angle,
  output logic                                done,
  output logic signed [gado_pkg::C16_W-1:0]   cos16,
  output logic signed [gado_pkg::C16_W-1:0]   sin16
);

  localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

  logic                              busy;
  logic                              fin;
  logic [CNT_W-1:0]                  cnt;
  logic signed [gado_pkg::CW-1:0]    x;
  logic signed [gado_pkg::CW-1:0]    y;
  logic signed [gado_pkg::ZW-1:0]    z;
  logic [1:0]                        q;

  logic [gado_pkg::ANG_W-1:0]        biased;
  logic [1:0]                        q_in;
  logic [gado_pkg::ANG_W-1:0]        r_in;
  logic signed [gado_pkg::CW-1:0]    x_shr;
  logic signed [gado_pkg::CW-1:0]    y_shr;
  logic signed [gado_pkg::ZW-1:0]    at;
  logic signed [gado_pkg::CW-1:0]    c_rot;
  logic signed [gado_pkg::CW-1:0]    s_rot;
  logic signed [gado_pkg::CW:0]      c_rnd;
  logic signed [gado_pkg::CW:0]      s_rnd;

  // quadrant and residual angle in [-1/8, 1/8) turn
  assign biased = angle + gado_pkg::OCTANT_BIAS;
  assign q_in   = biased[gado_pkg::ANG_W-1 -: 2];
  assign r_in   = angle - {q_in, {(gado_pkg::ANG_W-2){1'b0}}};

  assign x_shr = x >>> cnt;
  assign y_shr = y >>> cnt;
  assign at    = gado_pkg::atan_turn(gado_pkg::ATAN_IDX_W'(cnt));

  always_comb begin
    unique case (q)
      2'd0: begin c_rot = x;  s_rot = y;  end
      2'd1: begin c_rot = -y; s_rot = x;  end
      2'd2: begin c_rot = -x; s_rot = -y; end
      2'd3: begin c_rot = y;  s_rot = -x; end
      default: begin c_rot = x; s_rot = y; end
    endcase
  end

  assign c_rnd = {c_rot[gado_pkg::CW-1], c_rot} + gado_pkg::C_RND_HALF;
  assign s_rnd = {s_rot[gado_pkg::CW-1], s_rot} + gado_pkg::C_RND_HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= fin;
      fin  <= busy && (cnt == LAST);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == LAST)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x   <= gado_pkg::CORDIC_K;
      y   <= '0;
      z   <= {r_in, {(gado_pkg::ZW-gado_pkg::ANG_W){1'b0}}};
      q   <= q_in;
      cnt <= '0;
    end else if (busy) begin
      if (!z[gado_pkg::ZW-1]) begin
        x <= x - y_shr;
        y <= y + x_shr;
        z <= z - at;
      end else begin
        x <= x + y_shr;
        y <= y - x_shr;
        z <= z + at;
      end
      cnt <= cnt + 1'b1;
    end
    if (fin) begin
      cos16 <= c_rnd[gado_pkg::C16_W+13:14];
      sin16 <= s_rnd[gado_pkg::C16_W+13:14];
    end
  end

endmodule

>>> hdl/gyro_aided_drive_odometry_core.sv
// Gyro-aided dead-reckoning odometry: sums encoder deltas, scales, rotates by heading, integrates x/y.
// Sample accept in idle, then the CORDIC loop (one micro-rotation per cycle), then a cos pass and a
//   sin pass through the shared travel-by-sin/cos multiplier, then the x/y update.
// A new sample is taken only after the update of the previous one has been committed.
// A finished result waits in the output register while the next sample is already being processed.
// Reset (synchronous, active high): gain 3304, x 9216, y 3072, no result pending, ready for a sample.
module gyro_aided_drive_odometry_core #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [gado_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gado_pkg::CFG_DATA_W-1:0]     cfg_data,
  gado_sample_if.sink                         sample,
  gado_result_if.source                       result
);

  gado_pkg::state_t                        state;
  gado_pkg::state_t                        state_next;

  logic [gado_pkg::GAIN_W-1:0]             travel_gain;
  logic signed [gado_pkg::POS_W-1:0]       x_position;
  logic signed [gado_pkg::POS_W-1:0]       y_position;
  logic signed [gado_pkg::SUM_W-1:0]       sum;
  logic [gado_pkg::ANG_W-1:0]              heading;
  logic [gado_pkg::ANG_W-1:0]              heading_out;
  logic signed [gado_pkg::TRAVEL_W-1:0]    travel;
  logic signed [gado_pkg::PROD_W-1:0]      prod;
  logic signed [gado_pkg::STEP_W-1:0]      dx;
  logic                                    out_valid;

  logic                                    accept;
  logic                                    cordic_done;
  logic signed [gado_pkg::C16_W-1:0]       cos16;
  logic signed [gado_pkg::C16_W-1:0]       sin16;
  logic signed [gado_pkg::C16_W-1:0]       mul_b;
  logic signed [gado_pkg::GAIN_W:0]        gain_s;
  logic signed [gado_pkg::SUM_W-1:0]       sum_in;
  logic signed [gado_pkg::PROD_W:0]        x_rnd;
  logic signed [gado_pkg::PROD_W:0]        y_rnd;
  logic signed [gado_pkg::STEP_W-1:0]      dy;
  logic signed [gado_pkg::POS_W:0]         x_sum;
  logic signed [gado_pkg::POS_W:0]         y_sum;
  logic                                    out_free;
  logic                                    commit;

  assign accept   = sample.valid && sample.ready;
  assign out_free = !out_valid || result.ready;
  assign commit   = (state == gado_pkg::ST_UPD) && out_free;

  assign sum_in = gado_pkg::SUM_W'(sample.left_front_delta)
                + gado_pkg::SUM_W'(sample.left_middle_delta)
                + gado_pkg::SUM_W'(sample.left_back_delta)
                + gado_pkg::SUM_W'(sample.right_front_delta)
                + gado_pkg::SUM_W'(sample.right_middle_delta)
                + gado_pkg::SUM_W'(sample.right_back_delta);

  assign gain_s = {1'b0, travel_gain};
  assign mul_b  = (state == gado_pkg::ST_MULX) ? cos16 : sin16;

  // round half up of -P*cos / 2^32 and P*sin / 2^32
  assign x_rnd = gado_pkg::RND_HALF - {prod[gado_pkg::PROD_W-1], prod};
  assign y_rnd = {prod[gado_pkg::PROD_W-1], prod} + gado_pkg::RND_HALF;
  assign dy    = y_rnd[gado_pkg::STEP_W+31:32];

  assign x_sum = (gado_pkg::POS_W+1)'(x_position) + (gado_pkg::POS_W+1)'(dx);
  assign y_sum = (gado_pkg::POS_W+1)'(y_position) + (gado_pkg::POS_W+1)'(dy);

  gado_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .angle (sample.heading_angle),
    .done  (cordic_done),
    .cos16 (cos16),
    .sin16 (sin16)
  );

  always_comb begin
    state_next   = state;
    sample.ready = 1'b0;
    unique case (state)
      gado_pkg::ST_IDLE: begin
        sample.ready = 1'b1;
        if (sample.valid) begin
          state_next = gado_pkg::ST_CORDIC;
        end
      end
      gado_pkg::ST_CORDIC: begin
        if (cordic_done) begin
          state_next = gado_pkg::ST_MULX;
        end
      end
      gado_pkg::ST_MULX: state_next = gado_pkg::ST_MULY;
      gado_pkg::ST_MULY: state_next = gado_pkg::ST_UPD;
      gado_pkg::ST_UPD: begin
        if (out_free) begin
          state_next = gado_pkg::ST_IDLE;
        end
      end
      default: state_next = gado_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gado_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      travel_gain <= gado_pkg::TRAVEL_GAIN_RST;
      x_position  <= gado_pkg::START_X_RST;
      y_position  <= gado_pkg::START_Y_RST;
      out_valid   <= 1'b0;
    end else begin
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      // register writes take priority; the user must issue them only while idle, the block does not enforce it
      if (cfg_we) begin
        unique case (cfg_index)
          gado_pkg::CFG_TRAVEL_GAIN: travel_gain <= cfg_data[gado_pkg::GAIN_W-1:0];
          gado_pkg::CFG_START_X:     x_position  <= cfg_data[gado_pkg::POS_W-1:0];
          gado_pkg::CFG_START_Y:     y_position  <= cfg_data[gado_pkg::POS_W-1:0];
          default: ;
        endcase
      end else if (commit) begin
        x_position <= gado_pkg::sat32(x_sum);
        y_position <= gado_pkg::sat32(y_sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sum     <= sum_in;
      heading <= sample.heading_angle;
    end
    if (state == gado_pkg::ST_CORDIC) begin
      travel <= gado_pkg::TRAVEL_W'(sum) * gado_pkg::TRAVEL_W'(gain_s);
    end
    if ((state == gado_pkg::ST_MULX) || (state == gado_pkg::ST_MULY)) begin
      prod <= gado_pkg::PROD_W'(travel) * gado_pkg::PROD_W'(mul_b);
    end
    if (state == gado_pkg::ST_MULY) begin
      dx <= x_rnd[gado_pkg::STEP_W+31:32];
    end
    if (commit) begin
      heading_out <= heading;
    end
  end

  assign result.valid       = out_valid;
  assign result.pos_x       = x_position;
  assign result.pos_y       = y_position;
  assign result.heading_out = heading_out;

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == gado_pkg::ST_CORDIC)
    else $error("accepted item did not start the CORDIC");

  a_done_in_cordic: assert property (@(posedge clk) disable iff (rst)
    cordic_done |-> state == gado_pkg::ST_CORDIC)
    else $error("CORDIC finished outside its wait state");

  a_upd_stall: assert property (@(posedge clk) disable iff (rst)
    (state == gado_pkg::ST_UPD) && out_valid && !result.ready && !cfg_we
    |=> (state == gado_pkg::ST_UPD) && $stable(x_position) && $stable(y_position))
    else $error("position changed while the previous result was still pending");

  a_start_x_load: assert property (@(posedge clk) disable iff (rst)
    cfg_we && (cfg_index == gado_pkg::CFG_START_X)
    |=> x_position == $past(cfg_data[gado_pkg::POS_W-1:0]))
    else $error("start_x write not loaded into x position");

  a_valid_drops: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.ready && (state != gado_pkg::ST_UPD) |=> !out_valid)
    else $error("result repeated after being taken");
`endif

endmodule

>>> tb/sv/gyro_aided_drive_odometry_core_test.sv
// Self-checking testbench for the drive odometry core: directed and random encoder ticks.
module gyro_aided_drive_odometry_core_test;

  localparam int STEPS = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS = 150;
  localparam int HOLD_AFTER = 200;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_PRINTED = 40;
  localparam logic [gado_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  // atan(2^-i), 2^32 per turn
  localparam longint ATAN_TURN [24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };

  typedef struct {
    logic signed [gado_pkg::DELTA_W-1:0] delta [6];
    logic [gado_pkg::ANG_W-1:0]          heading;
  } tick_t;

  typedef struct {
    logic signed [gado_pkg::POS_W-1:0] x;
    logic signed [gado_pkg::POS_W-1:0] y;
    logic [gado_pkg::ANG_W-1:0]        heading;
  } pose_t;

  class pose_tracker;
    logic [gado_pkg::GAIN_W-1:0]       gain;
    logic signed [gado_pkg::POS_W-1:0] x_pos;
    logic signed [gado_pkg::POS_W-1:0] y_pos;
    pose_t                             pending_poses[$];
    int                                mismatches;
    int                                poses_seen;

    function new();
      gain = gado_pkg::TRAVEL_GAIN_RST;
      x_pos = gado_pkg::START_X_RST;
      y_pos = gado_pkg::START_Y_RST;
      mismatches = 0;
      poses_seen = 0;
    endfunction

    function void write_reg(logic [gado_pkg::CFG_IDX_W-1:0] idx,
                            logic [gado_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        gado_pkg::CFG_TRAVEL_GAIN: gain = data[gado_pkg::GAIN_W-1:0];
        gado_pkg::CFG_START_X:     x_pos = data;
        gado_pkg::CFG_START_Y:     y_pos = data;
        default: ;
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // travel = sum * gain, rotated by heading via CORDIC, then x/y integrated
    function void note_sample(tick_t t);
      longint sum, travel, cx, cy, z, tx, ty, c, s, c16, s16, dx, dy, r;
      logic [gado_pkg::ANG_W:0]   biased;
      logic [1:0]                 quad;
      logic [gado_pkg::ANG_W-1:0] resid;
      pose_t                      want;
      sum = 0;
      for (int k = 0; k < 6; k++) sum += longint'(t.delta[k]);
      travel = sum * longint'(gain);
      biased = {1'b0, t.heading} + 17'd8192;
      quad = biased[15:14];
      resid = t.heading - {quad, 14'd0};
      r = longint'($signed(resid));
      cx = longint'(gado_pkg::CORDIC_K);
      cy = 0;
      z = r * 65536;
      for (int i = 0; i < STEPS && i < 24; i++) begin
        tx = cy >>> i;
        ty = cx >>> i;
        if (z >= 0) begin
          cx -= tx; cy += ty; z -= ATAN_TURN[i];
        end else begin
          cx += tx; cy -= ty; z += ATAN_TURN[i];
        end
      end
      case (quad)
        2'd1: begin c = -cy; s = cx; end
        2'd2: begin c = -cx; s = -cy; end
        2'd3: begin c = cy; s = -cx; end
        default: begin c = cx; s = cy; end
      endcase
      c16 = (c + 8192) >>> 14;
      s16 = (s + 8192) >>> 14;
      dx = (-(travel * c16) + (64'sd1 <<< 31)) >>> 32;
      dy = (travel * s16 + (64'sd1 <<< 31)) >>> 32;
      x_pos = 32'(clamp32(longint'(x_pos) + dx));
      y_pos = 32'(clamp32(longint'(y_pos) + dy));
      want.x = x_pos;
      want.y = y_pos;
      want.heading = t.heading;
      pending_poses.push_back(want);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= MAX_PRINTED) $display("mismatch: %s", what);
    endtask

    task check_pose(logic signed [gado_pkg::POS_W-1:0] px, logic signed [gado_pkg::POS_W-1:0] py,
                    logic [gado_pkg::ANG_W-1:0] ph);
      pose_t want;
      poses_seen++;
      if (pending_poses.size() == 0) begin
        report_mismatch($sformatf("pose with none pending x=%0d y=%0d heading=%0d",
                                  px, py, ph));
        return;
      end
      want = pending_poses.pop_front();
      if (px !== want.x)
        report_mismatch($sformatf("pose %0d pos_x got %0d want %0d", poses_seen, px, want.x));
      if (py !== want.y)
        report_mismatch($sformatf("pose %0d pos_y got %0d want %0d", poses_seen, py, want.y));
      if (ph !== want.heading)
        report_mismatch($sformatf("pose %0d heading_out got %0d want %0d",
                                  poses_seen, ph, want.heading));
    endtask
  endclass

  logic                            clk;
  logic                            rst;
  logic                            cfg_we;
  logic [gado_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [gado_pkg::CFG_DATA_W-1:0] cfg_data;
  int                              cycle_count;
  pose_tracker                     tracker = new();

  gado_sample_if sample_ch ();
  gado_result_if result_ch ();

  gyro_aided_drive_odometry_core #(.CORDIC_STEPS(STEPS)) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample_ch),
    .result    (result_ch)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready)
      tracker.check_pose(result_ch.pos_x, result_ch.pos_y, result_ch.heading_out);
  end

  // result side: stall patterns, plus one long hold-off so the core backs up
  initial begin : result_drain
    int mode, span, phase_cnt;
    bit held;
    held = 1'b0;
    phase_cnt = 0;
    result_ch.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 150);
      repeat (span) begin
        @(negedge clk);
        phase_cnt++;
        if (!held && tracker.poses_seen >= HOLD_AFTER) begin
          held = 1'b1;
          result_ch.ready = 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
        end
        case (mode)
          0: result_ch.ready = 1'b1;
          1: result_ch.ready = 1'($urandom_range(0, 1));
          2: result_ch.ready = ($urandom_range(0, 4) == 0);
          default: result_ch.ready = ((phase_cnt / 3) % 2 == 0);
        endcase
      end
    end
  end

  task automatic send_sample(tick_t t);
    @(negedge clk);
    sample_ch.valid = 1'b1;
    sample_ch.left_front_delta = t.delta[0];
    sample_ch.left_middle_delta = t.delta[1];
    sample_ch.left_back_delta = t.delta[2];
    sample_ch.right_front_delta = t.delta[3];
    sample_ch.right_middle_delta = t.delta[4];
    sample_ch.right_back_delta = t.delta[5];
    sample_ch.heading_angle = t.heading;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    tracker.note_sample(t);
  endtask

  task automatic pause_samples(int n);
    if (n == 0) return;
    @(negedge clk);
    sample_ch.valid = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic send_uniform(logic signed [gado_pkg::DELTA_W-1:0] d,
                              logic [gado_pkg::ANG_W-1:0] h);
    tick_t t;
    for (int k = 0; k < 6; k++) t.delta[k] = d;
    t.heading = h;
    send_sample(t);
  endtask

  task automatic wait_drained();
    pause_samples(1);
    while (tracker.pending_poses.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [gado_pkg::CFG_IDX_W-1:0] idx,
                           logic [gado_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    tracker.write_reg(idx, data);
  endtask

  task automatic feed_random(int count);
    tick_t t;
    int sent, burst, pick;
    sent = 0;
    while (sent < count) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
      for (int b = 0; b < burst && sent < count; b++) begin
        pick = $urandom_range(0, 15);
        for (int k = 0; k < 6; k++) begin
          if (pick < 3) t.delta[k] = 16'($urandom_range(0, 400) - 200);
          else if (pick == 3) t.delta[k] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
          else t.delta[k] = 16'($urandom);
        end
        // quadrant boundaries now and then
        if ($urandom_range(0, 7) == 0)
          t.heading = 16'($urandom_range(0, 3) * 16384 + 8191 + $urandom_range(0, 1));
        else
          t.heading = 16'($urandom);
        send_sample(t);
        sent++;
      end
      pause_samples(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
    end
  endtask

  initial begin : stimulus
    tick_t t;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = gado_pkg::CFG_TRAVEL_GAIN;
    cfg_data = '0;
    sample_ch.valid = 1'b0;
    sample_ch.left_front_delta = '0;
    sample_ch.left_middle_delta = '0;
    sample_ch.left_back_delta = '0;
    sample_ch.right_front_delta = '0;
    sample_ch.right_middle_delta = '0;
    sample_ch.right_back_delta = '0;
    sample_ch.heading_angle = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset gain and start position; axes and quadrant edges
    send_uniform(16'sd0, 16'd0);
    send_uniform(16'sd32767, 16'd0);
    send_uniform(-16'sd32768, 16'd16384);
    send_uniform(16'sd32767, 16'd32768);
    for (int k = 0; k < 6; k++) t.delta[k] = (k < 3) ? 16'sd32767 : -16'sd32768;
    t.heading = 16'd49152;
    send_sample(t);
    send_uniform(16'sd1000, 16'd8191);
    send_uniform(16'sd1000, 16'd8192);
    send_uniform(-16'sd1000, 16'd24575);
    send_uniform(-16'sd1000, 16'd24576);
    send_uniform(16'sd777, 16'd40959);
    send_uniform(16'sd777, 16'd40960);
    send_uniform(-16'sd5, 16'd57343);
    send_uniform(-16'sd5, 16'd57344);
    send_uniform(16'sd12345, 16'd65535);
    wait_drained();

    // out-of-range index must be ignored; push x up and y down into the limits
    write_reg(CFG_UNMAPPED, 32'h0000_0001);
    write_reg(gado_pkg::CFG_TRAVEL_GAIN, 32'h0000_FFFF);
    write_reg(gado_pkg::CFG_START_X, 32'h7FFF_FF00);
    write_reg(gado_pkg::CFG_START_Y, 32'h8000_0100);
    send_uniform(16'sd32767, 16'd32768);
    send_uniform(16'sd32767, 16'd49152);
    send_uniform(16'sd32767, 16'd32768);
    send_uniform(16'sd32767, 16'd49152);
    wait_drained();

    // x down and y up into the other limits, then zero gain
    write_reg(gado_pkg::CFG_START_X, 32'h8000_0000);
    write_reg(gado_pkg::CFG_START_Y, 32'h7FFF_FFFF);
    send_uniform(16'sd32767, 16'd0);
    send_uniform(16'sd32767, 16'd16384);
    wait_drained();
    write_reg(gado_pkg::CFG_TRAVEL_GAIN, 32'h0000_0000);
    send_uniform(16'sd32767, 16'd8000);
    send_uniform(-16'sd32768, 16'd40000);
    wait_drained();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin
          write_reg(gado_pkg::CFG_TRAVEL_GAIN, 32'(gado_pkg::TRAVEL_GAIN_RST));
          write_reg(gado_pkg::CFG_START_X, $urandom);
          write_reg(gado_pkg::CFG_START_Y, $urandom);
        end
        1: begin
          write_reg(gado_pkg::CFG_TRAVEL_GAIN, 32'h0000_FFFF);
          write_reg(gado_pkg::CFG_START_X, 32'h7FF8_0000 + $urandom_range(0, 65535));
          write_reg(gado_pkg::CFG_START_Y, 32'h8008_0000 - $urandom_range(0, 65535));
        end
        2: begin
          write_reg(gado_pkg::CFG_TRAVEL_GAIN, $urandom_range(0, 65535));
          write_reg(gado_pkg::CFG_START_X, 32'h0);
          write_reg(gado_pkg::CFG_START_Y, 32'h0);
        end
        3: begin
          write_reg(gado_pkg::CFG_TRAVEL_GAIN, $urandom_range(1, 255));
          write_reg(gado_pkg::CFG_START_X, $urandom);
          write_reg(gado_pkg::CFG_START_Y, $urandom);
        end
        4: begin
          write_reg(gado_pkg::CFG_TRAVEL_GAIN, 32'h0000_0001);
          write_reg(gado_pkg::CFG_START_Y, 32'h7FFF_FFFF);
          write_reg(gado_pkg::CFG_START_X, 32'h8000_0000);
        end
        default: begin
          write_reg(gado_pkg::CFG_TRAVEL_GAIN, $urandom_range(0, 65535));
          write_reg(gado_pkg::CFG_START_X, 32'h8008_0000 - $urandom_range(0, 65535));
          write_reg(gado_pkg::CFG_START_Y, 32'h7FF8_0000 + $urandom_range(0, 65535));
        end
      endcase
      feed_random(PHASE_ITEMS);
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_poses.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
